// File: rtl/tsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_pkg
// Request and status codes, widths and the control bundle shared by the
// two-set membership table modules.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int KEY_W       = 64;
    localparam int COUNT_W     = 5;
    localparam int MAX_RESULTS = 32;
    localparam int NUM_W       = 6;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [NUM_W-1:0]   num_t;

    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_REMOVE   = 3'd1;
    localparam logic [2:0] REQ_CONTAINS = 3'd2;
    localparam logic [2:0] REQ_UNION    = 3'd3;
    localparam logic [2:0] REQ_INTER    = 3'd4;
    localparam logic [2:0] REQ_DIFF     = 3'd5;
    localparam logic [2:0] REQ_LIST     = 3'd6;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_DUP    = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;
    localparam logic [1:0] STATUS_ABSENT = 2'd3;

    // sequencer to result stage
    typedef struct packed {
        logic       push;
        logic       fin;
        key_t       elem;
        logic       found;
        logic [1:0] status;
        count_t     count;
    } emit_ctl_t;

endpackage
`default_nettype wire

// File: rtl/tsm_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_store
// Key store of one set: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module tsm_store
    import tsm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire key_t          wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output key_t               rd_data
);

    key_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/tsm_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_emit
// Result stage: holds the newest stream element back until the next one or
// the end of the request is known, so that last can be marked.
// ----------------------------------------------------------------------------
module tsm_emit
    import tsm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire emit_ctl_t ctl,
    output logic           result_strobe,
    output key_t           elem_value,
    output logic           elem_valid,
    output logic           found,
    output logic [1:0]     status,
    output count_t         set_count,
    output logic           last
);

    logic       strobe_reg, strobe_next;
    logic       pend_v_reg, pend_v_next;
    key_t       pend_val_reg, pend_val_next;
    num_t       num_reg, num_next;
    key_t       value_reg, value_next;
    logic       valid_reg, valid_next;
    logic       found_reg, found_next;
    logic [1:0] status_reg, status_next;
    count_t     count_reg, count_next;
    logic       last_reg, last_next;

    always_comb
    begin
        strobe_next   = 1'b0;
        pend_v_next   = pend_v_reg;
        pend_val_next = pend_val_reg;
        num_next      = num_reg;
        value_next    = value_reg;
        valid_next    = valid_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        last_next     = last_reg;

        // stream is cut once the item limit is reached
        if (ctl.push && (num_reg != NUM_W'(MAX_RESULTS)))
        begin
            if (pend_v_reg)
            begin
                strobe_next = 1'b1;
                value_next  = pend_val_reg;
                valid_next  = 1'b1;
                found_next  = 1'b0;
                status_next = STATUS_OK;
                count_next  = ctl.count;
                last_next   = 1'b0;
            end
            pend_v_next   = 1'b1;
            pend_val_next = ctl.elem;
            num_next      = num_reg + NUM_W'(1);
        end

        if (ctl.fin)
        begin
            strobe_next = 1'b1;
            count_next  = ctl.count;
            last_next   = 1'b1;
            if (pend_v_reg)
            begin
                value_next  = pend_val_reg;
                valid_next  = 1'b1;
                found_next  = 1'b0;
                status_next = STATUS_OK;
            end
            else
            begin
                value_next  = '0;
                valid_next  = 1'b0;
                found_next  = ctl.found;
                status_next = ctl.status;
            end
            pend_v_next = 1'b0;
            num_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            pend_v_reg <= 1'b0;
            num_reg    <= '0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            pend_v_reg <= pend_v_next;
            num_reg    <= num_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_val_reg <= pend_val_next;
        value_reg    <= value_next;
        valid_reg    <= valid_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign elem_value    = value_reg;
    assign elem_valid    = valid_reg;
    assign found         = found_reg;
    assign status        = status_reg;
    assign set_count     = count_reg;
    assign last          = last_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !elem_valid) |-> last)
        else $error("item without element is not the last of its transaction");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !elem_valid) |-> (elem_value == '0))
        else $error("item without element carries a value");

    a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
        num_reg <= NUM_W'(MAX_RESULTS))
        else $error("stream item count beyond limit");

endmodule
`default_nettype wire

// File: rtl/two_set_membership_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_set_membership_table_unit
// Two sets of 64-bit keys with insert, remove, contains, union,
// intersection, difference and listing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the request has produced its final result. Results come one per
// strobe and cannot be held off. Each set lives in its own memory with one
// read port, and every scan reads one entry per cycle. The result stage
// keeps one element back, so the last result of a transaction is on the
// ports in the first cycle that busy is low.
// ----------------------------------------------------------------------------
module two_set_membership_table_unit
    import tsm_pkg::*;
#(
    parameter int SET_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  req_type,
    input  wire logic        set_sel,
    input  wire key_t        key_value,
    output logic             result_strobe,
    output key_t             elem_value,
    output logic             elem_valid,
    output logic             found,
    output logic [1:0]       status,
    output count_t           set_count,
    output logic             last
);

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SRCH    = 3'd1;
    localparam logic [2:0] S_RMV     = 3'd2;
    localparam logic [2:0] S_WALK    = 3'd3;
    localparam logic [2:0] S_FETCH   = 3'd4;
    localparam logic [2:0] S_FETCH_W = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    req_reg, req_next;
    logic          sel_reg, sel_next;
    key_t          key_reg, key_next;
    logic [CW-1:0] lc_reg, lc_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic [CW-1:0] first_count_reg, first_count_next;
    logic [CW-1:0] second_count_reg, second_count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] oi_reg, oi_next;
    logic [CW-1:0] wj_reg, wj_next;
    logic          rv_reg, rv_next;
    logic          phase_reg, phase_next;
    logic          rd_phys_reg, rd_phys_next;

    logic          rd_en;
    logic          rd_side;
    logic [CW-1:0] rd_idx;
    logic          wr_en;
    logic [CW-1:0] wr_idx;
    key_t          wr_data;
    key_t          a_rd_data;
    key_t          b_rd_data;
    key_t          rd_data;
    logic          a_wr_en;
    logic          b_wr_en;
    logic          cnt_we;
    logic [CW-1:0] cnt_wdata;
    logic          hit;
    logic          srch_right;
    logic [CW-1:0] srch_cnt;
    logic [CW-1:0] outer_cnt;
    logic [NUM_W-1:0] lc_ext;
    logic [NUM_W-1:0] nc_ext;
    emit_ctl_t     emit_ctl;

    assign rd_data    = rd_phys_reg ? b_rd_data : a_rd_data;
    assign srch_right = (req_reg == REQ_INTER) || (req_reg == REQ_DIFF);
    assign srch_cnt   = srch_right ? rc_reg : lc_reg;
    assign outer_cnt  = phase_reg ? rc_reg : lc_reg;
    assign hit        = rv_reg && (rd_data == key_reg);
    assign lc_ext     = NUM_W'(lc_reg);

    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        sel_next          = sel_reg;
        key_next          = key_reg;
        lc_next           = lc_reg;
        rc_next           = rc_reg;
        scan_next         = scan_reg;
        oi_next           = oi_reg;
        wj_next           = wj_reg;
        rv_next           = rv_reg;
        phase_next        = phase_reg;
        rd_en             = 1'b0;
        rd_side           = SIDE_LEFT;
        rd_idx            = scan_reg;
        wr_en             = 1'b0;
        wr_idx            = wj_reg;
        wr_data           = rd_data;
        cnt_we            = 1'b0;
        cnt_wdata         = lc_reg;
        nc_ext            = lc_ext;
        emit_ctl          = '0;
        emit_ctl.elem     = key_reg;
        emit_ctl.count    = lc_ext[COUNT_W-1:0];
        emit_ctl.status   = STATUS_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    sel_next   = set_sel;
                    key_next   = key_value;
                    lc_next    = set_sel ? second_count_reg : first_count_reg;
                    rc_next    = set_sel ? first_count_reg : second_count_reg;
                    scan_next  = '0;
                    oi_next    = '0;
                    rv_next    = 1'b0;
                    phase_next = 1'b0;
                    unique case (req_type)
                        REQ_INSERT, REQ_REMOVE, REQ_CONTAINS: state_next = S_SRCH;
                        REQ_UNION, REQ_LIST:                  state_next = S_WALK;
                        REQ_INTER, REQ_DIFF:                  state_next = S_FETCH;
                        default:                              state_next = S_FIN;
                    endcase
                end
            end

            // one entry read per cycle, compared the cycle after
            S_SRCH:
            begin
                rd_side = srch_right ? SIDE_RIGHT : SIDE_LEFT;
                if (hit || (scan_reg == srch_cnt))
                begin
                    rv_next = 1'b0;
                    unique case (req_reg)
                        REQ_CONTAINS:
                        begin
                            emit_ctl.fin   = 1'b1;
                            emit_ctl.found = hit;
                            state_next     = S_IDLE;
                        end
                        REQ_INSERT:
                        begin
                            emit_ctl.fin = 1'b1;
                            state_next   = S_IDLE;
                            if (hit)
                            begin
                                emit_ctl.found  = 1'b1;
                                emit_ctl.status = STATUS_DUP;
                            end
                            else if (lc_reg == CW'(SET_DEPTH))
                            begin
                                emit_ctl.status = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_idx         = lc_reg;
                                wr_data        = key_reg;
                                cnt_we         = 1'b1;
                                cnt_wdata      = lc_reg + CW'(1);
                                nc_ext         = NUM_W'(cnt_wdata);
                                emit_ctl.count = nc_ext[COUNT_W-1:0];
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (hit)
                            begin
                                scan_next  = '0;
                                wj_next    = '0;
                                state_next = S_RMV;
                            end
                            else
                            begin
                                emit_ctl.fin    = 1'b1;
                                emit_ctl.status = STATUS_ABSENT;
                                state_next      = S_IDLE;
                            end
                        end
                        REQ_INTER:
                        begin
                            emit_ctl.push = hit;
                            oi_next       = oi_reg + CW'(1);
                            state_next    = S_FETCH;
                        end
                        REQ_UNION, REQ_DIFF:
                        begin
                            emit_ctl.push = !hit;
                            oi_next       = oi_reg + CW'(1);
                            state_next    = S_FETCH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_idx    = scan_reg;
                    scan_next = scan_reg + CW'(1);
                    rv_next   = 1'b1;
                end
            end

            // compaction: write back every entry that differs from the key
            S_RMV:
            begin
                rd_side = SIDE_LEFT;
                if (rv_reg && (rd_data != key_reg))
                begin
                    wr_en   = 1'b1;
                    wr_idx  = wj_reg;
                    wr_data = rd_data;
                    wj_next = wj_reg + CW'(1);
                end
                if (scan_reg != lc_reg)
                begin
                    rd_en     = 1'b1;
                    rd_idx    = scan_reg;
                    scan_next = scan_reg + CW'(1);
                    rv_next   = 1'b1;
                end
                else
                begin
                    rv_next = 1'b0;
                    if (rv_reg)
                    begin
                        cnt_we         = 1'b1;
                        cnt_wdata      = wj_next;
                        nc_ext         = NUM_W'(wj_next);
                        emit_ctl.fin   = 1'b1;
                        emit_ctl.found = 1'b1;
                        emit_ctl.count = nc_ext[COUNT_W-1:0];
                        state_next     = S_IDLE;
                    end
                end
            end

            S_WALK:
            begin
                rd_side = SIDE_LEFT;
                if (rv_reg)
                begin
                    emit_ctl.push = 1'b1;
                    emit_ctl.elem = rd_data;
                end
                if (scan_reg != lc_reg)
                begin
                    rd_en     = 1'b1;
                    rd_idx    = scan_reg;
                    scan_next = scan_reg + CW'(1);
                    rv_next   = 1'b1;
                end
                else
                begin
                    rv_next = 1'b0;
                    if (!rv_reg)
                    begin
                        if (req_reg == REQ_UNION)
                        begin
                            phase_next = 1'b1;
                            oi_next    = '0;
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            emit_ctl.fin = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                end
            end

            // outer loop of union second half, intersection and difference
            S_FETCH:
            begin
                rd_side = phase_reg ? SIDE_RIGHT : SIDE_LEFT;
                if (oi_reg == outer_cnt)
                begin
                    emit_ctl.fin = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = oi_reg;
                    state_next = S_FETCH_W;
                end
            end

            S_FETCH_W:
            begin
                key_next   = rd_data;
                scan_next  = '0;
                rv_next    = 1'b0;
                state_next = S_SRCH;
            end

            S_FIN:
            begin
                emit_ctl.fin = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        if (cnt_we)
        begin
            if (sel_reg)
            begin
                second_count_next = cnt_wdata;
            end
            else
            begin
                first_count_next = cnt_wdata;
            end
        end

        rd_phys_next = rd_en ? (rd_side ^ sel_reg) : rd_phys_reg;
    end

    assign a_wr_en = wr_en && !sel_reg;
    assign b_wr_en = wr_en && sel_reg;
    assign busy    = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            rv_reg           <= 1'b0;
            phase_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            rv_reg           <= rv_next;
            phase_reg        <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        sel_reg     <= sel_next;
        key_reg     <= key_next;
        lc_reg      <= lc_next;
        rc_reg      <= rc_next;
        scan_reg    <= scan_next;
        oi_reg      <= oi_next;
        wj_reg      <= wj_next;
        rd_phys_reg <= rd_phys_next;
    end

    tsm_store #(
        .DEPTH (SET_DEPTH),
        .AW    (AW)
    ) u_first_store (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (a_rd_data)
    );

    tsm_store #(
        .DEPTH (SET_DEPTH),
        .AW    (AW)
    ) u_second_store (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (b_rd_data)
    );

    tsm_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (emit_ctl),
        .result_strobe (result_strobe),
        .elem_value    (elem_value),
        .elem_valid    (elem_valid),
        .found         (found),
        .status        (status),
        .set_count     (set_count),
        .last          (last)
    );

    a_push_fin_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit_ctl.push && emit_ctl.fin))
        else $error("element and end of transaction in the same cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= CW'(SET_DEPTH)) && (second_count_reg <= CW'(SET_DEPTH)))
        else $error("set count beyond depth");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (a_wr_en || b_wr_en) |-> busy)
        else $error("store write while idle");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !result_strobe)
        else $error("result right after the last of a transaction");

endmodule
`default_nettype wire

// File: tb/sv/tsm_result_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_result_checker
// Watches the request and result channels of the two-set membership table.
// It keeps its own copy of both key sets and predicts the results of every
// accepted request. Each result strobe is compared field by field with the
// oldest prediction. It reports the mismatch count and the number of results
// still owed.
// ----------------------------------------------------------------------------
module tsm_result_checker
    import tsm_pkg::*;
#(
    parameter int SET_DEPTH = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [2:0] req_type,
    input  wire logic       set_sel,
    input  wire key_t       key_value,
    input  wire logic       result_strobe,
    input  wire key_t       elem_value,
    input  wire logic       elem_valid,
    input  wire logic       found,
    input  wire logic [1:0] status,
    input  wire count_t     set_count,
    input  wire logic       last,
    output int              mismatch_count,
    output int              pending_count
);

    typedef struct packed {
        key_t       elem;
        logic       valid;
        logic       found;
        logic [1:0] status;
        count_t     count;
        logic       last;
    } membership_result_t;

    key_t               set_keys [2][SET_DEPTH];
    int unsigned        set_len  [2];
    membership_result_t expected_results [$];
    int                 failures = 0;

    function automatic bit holds_key(input int unsigned which, input int unsigned len,
                                     input key_t key);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (set_keys[which][i] === key)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        failures++;
        if (failures <= 10)
            $display("%0t tsm checker: %s mismatch, expected %h, got %h",
                     $time, what, want_v, got_v);
    endtask

    task automatic predict_request(input logic [2:0] req, input logic sel, input key_t key);
        int unsigned        lhs;
        int unsigned        rhs;
        int unsigned        lc;
        int unsigned        rc;
        int unsigned        keep;
        bit                 present;
        bit                 streamed;
        key_t               elems [$];
        membership_result_t res;
        lhs      = sel ? 1 : 0;
        rhs      = sel ? 0 : 1;
        lc       = set_len[lhs];
        rc       = set_len[rhs];
        present  = holds_key(lhs, lc, key);
        streamed = 1'b1;
        res      = '0;
        res.last = 1'b1;
        case (req)
            REQ_INSERT:
            begin
                streamed = 1'b0;
                if (present)
                begin
                    res.found  = 1'b1;
                    res.status = STATUS_DUP;
                end
                else if (lc >= SET_DEPTH)
                    res.status = STATUS_FULL;
                else
                begin
                    set_keys[lhs][lc] = key;
                    lc++;
                    set_len[lhs] = lc;
                end
            end
            REQ_REMOVE:
            begin
                streamed = 1'b0;
                if (present)
                begin
                    // close the gap, order kept
                    keep = 0;
                    for (int unsigned i = 0; i < lc; i++)
                    begin
                        if (set_keys[lhs][i] !== key)
                        begin
                            set_keys[lhs][keep] = set_keys[lhs][i];
                            keep++;
                        end
                    end
                    lc           = keep;
                    set_len[lhs] = lc;
                    res.found    = 1'b1;
                end
                else
                    res.status = STATUS_ABSENT;
            end
            REQ_CONTAINS:
            begin
                streamed  = 1'b0;
                res.found = present;
            end
            REQ_UNION:
            begin
                for (int unsigned i = 0; i < lc; i++)
                    elems.push_back(set_keys[lhs][i]);
                for (int unsigned i = 0; i < rc; i++)
                begin
                    if (!holds_key(lhs, lc, set_keys[rhs][i]))
                        elems.push_back(set_keys[rhs][i]);
                end
            end
            REQ_INTER:
            begin
                for (int unsigned i = 0; i < lc; i++)
                begin
                    if (holds_key(rhs, rc, set_keys[lhs][i]))
                        elems.push_back(set_keys[lhs][i]);
                end
            end
            REQ_DIFF:
            begin
                for (int unsigned i = 0; i < lc; i++)
                begin
                    if (!holds_key(rhs, rc, set_keys[lhs][i]))
                        elems.push_back(set_keys[lhs][i]);
                end
            end
            REQ_LIST:
            begin
                for (int unsigned i = 0; i < lc; i++)
                    elems.push_back(set_keys[lhs][i]);
            end
            default:
                streamed = 1'b0;
        endcase
        res.count = count_t'(lc);
        if (!streamed || elems.size() == 0)
            expected_results.push_back(res);
        else
        begin
            // stream is cut at the result limit
            while (elems.size() > MAX_RESULTS)
                void'(elems.pop_back());
            res.valid = 1'b1;
            foreach (elems[i])
            begin
                res.elem = elems[i];
                res.last = (i == elems.size() - 1);
                expected_results.push_back(res);
            end
        end
    endtask

    always @(posedge clk)
    begin : watch
        membership_result_t want;
        if (!rst_n)
        begin
            set_len[0] = 0;
            set_len[1] = 0;
            expected_results.delete();
        end
        else
        begin
            if (result_strobe)
            begin
                if (expected_results.size() == 0)
                    flag_mismatch("unexpected result, elem_value", '0, elem_value);
                else
                begin
                    want = expected_results.pop_front();
                    if (elem_value !== want.elem)
                        flag_mismatch("elem_value", want.elem, elem_value);
                    if (elem_valid !== want.valid)
                        flag_mismatch("elem_valid", want.valid, elem_valid);
                    if (found !== want.found)
                        flag_mismatch("found", want.found, found);
                    if (status !== want.status)
                        flag_mismatch("status", want.status, status);
                    if (set_count !== want.count)
                        flag_mismatch("set_count", want.count, set_count);
                    if (last !== want.last)
                        flag_mismatch("last", want.last, last);
                end
            end
            // results of this edge are checked before the new transaction's
            if (start && !busy)
                predict_request(req_type, set_sel, key_value);
        end
        mismatch_count <= failures;
        pending_count  <= expected_results.size();
    end

endmodule
`default_nettype wire

// File: tb/sv/two_set_membership_table_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_set_membership_table_unit_tb
// Drives requests into the two-set membership table: a directed opening that
// covers empty streams, +0/-0 and NaN bit patterns, a full set, duplicates,
// removal and every request code, then random phases built on small key
// pools so that sets overlap, fill up and drain. A checker beside the block
// predicts and compares all results.
// ----------------------------------------------------------------------------
module two_set_membership_table_unit_tb;
    import tsm_pkg::*;

    localparam int         SET_DEPTH  = 16;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    localparam key_t KEY_ZERO     = 64'h0000_0000_0000_0000;
    localparam key_t KEY_NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam key_t KEY_NAN      = 64'h7FF8_0000_0000_0000;
    localparam key_t KEY_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic [2:0] req_type  = REQ_INSERT;
    logic       set_sel   = 1'b0;
    key_t       key_value = '0;
    logic       busy;
    logic       result_strobe;
    key_t       elem_value;
    logic       elem_valid;
    logic       found;
    logic [1:0] status;
    count_t     set_count;
    logic       last;
    int         mismatches;
    int         results_owed;

    key_t key_pool [32];

    always #5 clk = ~clk;

    two_set_membership_table_unit #(
        .SET_DEPTH(SET_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .set_sel      (set_sel),
        .key_value    (key_value),
        .result_strobe(result_strobe),
        .elem_value   (elem_value),
        .elem_valid   (elem_valid),
        .found        (found),
        .status       (status),
        .set_count    (set_count),
        .last         (last)
    );

    tsm_result_checker #(
        .SET_DEPTH(SET_DEPTH)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .set_sel       (set_sel),
        .key_value     (key_value),
        .result_strobe (result_strobe),
        .elem_value    (elem_value),
        .elem_valid    (elem_valid),
        .found         (found),
        .status        (status),
        .set_count     (set_count),
        .last          (last),
        .mismatch_count(mismatches),
        .pending_count (results_owed)
    );

    // returns at the edge that accepted the transaction
    task automatic issue_request(input logic [2:0] req, input logic sel, input key_t key);
        start     <= 1'b1;
        req_type  <= req;
        set_sel   <= sel;
        key_value <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int unsigned cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic key_t random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic key_t pick_key(input int unsigned span);
        if ($urandom_range(0, 9) == 0)
            return random_key();
        return key_pool[$urandom_range(0, span - 1)];
    endfunction

    function automatic logic [2:0] pick_request(input int unsigned insert_pct,
                                                input int unsigned remove_pct);
        int unsigned roll;
        int unsigned base;
        roll = $urandom_range(0, 99);
        base = insert_pct + remove_pct;
        if (roll < insert_pct)
            return REQ_INSERT;
        if (roll < base)
            return REQ_REMOVE;
        if (roll < base + 15)
            return REQ_CONTAINS;
        if (roll < base + 21)
            return REQ_UNION;
        if (roll < base + 27)
            return REQ_INTER;
        if (roll < base + 33)
            return REQ_DIFF;
        if (roll < base + 39)
            return REQ_LIST;
        if (roll < base + 41)
            return REQ_UNUSED;
        return REQ_INSERT;
    endfunction

    task automatic send_directed(input logic [2:0] req, input logic sel, input key_t key);
        issue_request(req, sel, key);
        hold_off(pick_gap());
    endtask

    initial
    begin
        int unsigned spans       [4] = '{6, 20, 32, 12};
        int unsigned insert_pcts [4] = '{45, 45, 40, 20};
        int unsigned remove_pcts [4] = '{10, 15, 15, 40};
        bit          packed_run  [4] = '{1'b0, 1'b1, 1'b0, 1'b0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stream
        send_directed(REQ_LIST, 1'b0, random_key());
        // second set: zero, negative zero, nan, all ones, then fill up
        send_directed(REQ_INSERT, 1'b1, KEY_ZERO);
        send_directed(REQ_INSERT, 1'b1, KEY_NEG_ZERO);
        send_directed(REQ_INSERT, 1'b1, KEY_NAN);
        send_directed(REQ_INSERT, 1'b1, KEY_ONES);
        for (int i = 4; i < SET_DEPTH; i++)
            send_directed(REQ_INSERT, 1'b1, random_key());
        // full set, then a duplicate that must win over full
        send_directed(REQ_INSERT, 1'b1, 64'h0123_4567_89AB_CDEF);
        send_directed(REQ_INSERT, 1'b1, KEY_ZERO);
        send_directed(REQ_INSERT, 1'b0, KEY_ZERO);
        send_directed(REQ_INSERT, 1'b0, 64'h0000_0000_0000_0001);
        // +0 and -0 are different keys
        send_directed(REQ_CONTAINS, 1'b0, KEY_NEG_ZERO);
        send_directed(REQ_UNION, 1'b0, random_key());
        send_directed(REQ_INTER, 1'b1, random_key());
        send_directed(REQ_DIFF, 1'b0, random_key());
        send_directed(REQ_REMOVE, 1'b1, KEY_ZERO);
        send_directed(REQ_REMOVE, 1'b1, KEY_ZERO);
        send_directed(REQ_UNUSED, 1'b0, KEY_ONES);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            foreach (key_pool[i])
                key_pool[i] = random_key();
            key_pool[0] = KEY_ZERO;
            key_pool[1] = KEY_ONES;
            key_pool[2] = KEY_NEG_ZERO;
            key_pool[3] = KEY_NAN;
            for (int n = 0; n < 50; n++)
            begin
                issue_request(pick_request(insert_pcts[phase], remove_pcts[phase]),
                              1'($urandom_range(0, 1)), pick_key(spans[phase]));
                if (!packed_run[phase])
                    hold_off(pick_gap());
            end
            // sender waits for every owed result between phases
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("two_set_membership_table_unit_tb: done, clean");
        else
            $display("two_set_membership_table_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("two_set_membership_table_unit_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
